FILE: hw/rtl/bea_pkg.sv
// Shared types and constants of the bitmap extent allocator.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps

package bea_pkg;

	localparam int unsigned CFG_W = 13;

	typedef logic [1:0] status_t;

	localparam status_t ST_GRANTED  = 2'd0;
	localparam status_t ST_NO_SPACE = 2'd1;
	localparam status_t ST_RELEASED = 2'd2;
	localparam status_t ST_INVALID  = 2'd3;

	localparam logic REG_BLOCK_COUNT = 1'b0;
	localparam logic REG_RESERVED    = 1'b1;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = 13'd4096;
	localparam logic [CFG_W-1:0] RESERVED_RST    = 13'd6;

	localparam logic [7:0] BIT_ONE = 8'h01;

endpackage

FILE: hw/rtl/bitmap_extent_allocator.sv
// Top level of the bitmap extent allocator: sequencer, extent list and output register.
// Depends on bea_pkg and bea_map_ram.
//
//   port group   direction  handshake            contents
//   cfg          in         cfg_we               cfg_index, cfg_data
//   in           in         in_valid/in_ready    operation .. range_length
//   out          out        out_valid/out_ready  extent_start .. last
//
// After reset all NUM_BLOCKS/8 map bytes are cleared, one byte per cycle, before in_ready rises.
// Allocation: repeated subtraction counts the extents, then the scan tests one block per cycle
// except while a new map byte is fetched, then marking sets each granted block's bit through the
// single map port (S_MRD, S_MWR); releases clear each freed block's bit likewise (S_RRD, S_RWR).
// Each result waits in the output register until its transfer; no new item is taken meanwhile.
`timescale 1ns / 1ps

module bitmap_extent_allocator #(
	parameter int unsigned NUM_BLOCKS  = 4096,
	parameter int unsigned MAX_EXTENTS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [bea_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [12:0]                  required_blocks,
	input  logic [12:0]                  extent_size,
	input  logic [11:0]                  range_start,
	input  logic [12:0]                  range_length,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [11:0]                  extent_start,
	output logic [12:0]                  extent_length,
	output bea_pkg::status_t             status,
	output logic                         last
);
	import bea_pkg::*;

	localparam int unsigned BW    = $clog2(NUM_BLOCKS) + 1;
	localparam int unsigned WW    = ((BW > 13) ? BW : 13) + 1;
	localparam int unsigned BYTES = NUM_BLOCKS / 8;
	localparam int unsigned AW    = $clog2(BYTES);
	localparam int unsigned EW    = $clog2(MAX_EXTENTS + 2);
	localparam int unsigned IW    = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_LOAD  = 4'd4;
	localparam logic [3:0] S_LSET  = 4'd5;
	localparam logic [3:0] S_MRD   = 4'd6;
	localparam logic [3:0] S_MWR   = 4'd7;
	localparam logic [3:0] S_RRD   = 4'd8;
	localparam logic [3:0] S_RWR   = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0]       state_q;
	logic [12:0]      bc_q, rsv_q;
	logic [12:0]      rem_q, esz_q, run_q;
	logic [EW-1:0]    want_q, got_q, k_q;
	logic [WW-1:0]    pos_q, end_q;
	logic [AW-1:0]    clr_q, tag_q;
	logic             tag_vld_q;
	logic [WW-1:0]    found_q [MAX_EXTENTS];
	logic [WW-1:0]    found_rd_q;
	logic             out_valid_q, olast_q;
	logic [11:0]      ostart_q;
	logic [12:0]      olen_q;
	status_t          ostat_q;

	logic [WW-1:0]    hi_w, rel_end;
	logic [AW-1:0]    ram_addr;
	logic             ram_we;
	logic [7:0]       ram_wdata, ram_rdata, mask;
	logic             hit, found_we;

	assign hi_w = (WW'(bc_q) > WW'(NUM_BLOCKS)) ? WW'(NUM_BLOCKS) : WW'(bc_q);
	assign rel_end = ((WW'(range_start) + WW'(range_length)) > hi_w) ? hi_w
		: WW'(range_start) + WW'(range_length);
	assign mask = BIT_ONE << pos_q[2:0];
	assign hit = tag_vld_q && (tag_q == pos_q[AW+2:3]);

	always_comb begin
		ram_addr  = pos_q[AW+2:3];
		ram_we    = 1'b0;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_CLEAR: begin
				ram_addr  = clr_q;
				ram_we    = 1'b1;
				ram_wdata = 8'h00;
			end
			S_MWR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata | mask;
			end
			S_RWR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata & ~mask;
			end
			default: begin
			end
		endcase
	end

	bea_map_ram #(.DEPTH(BYTES)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign found_we = (state_q == S_SCAN) && (pos_q < hi_w) && (got_q < want_q) && hit
		&& !ram_rdata[pos_q[2:0]] && (13'(run_q + 13'd1) == esz_q);

	// Extent list: no reset, every entry is written by the scan before marking reads it.
	always_ff @(posedge clk) begin
		if (found_we) begin
			found_q[got_q[IW-1:0]] <= WW'(pos_q + WW'(1) - WW'(esz_q));
		end
		found_rd_q <= found_q[k_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			bc_q        <= BLOCK_COUNT_RST;
			rsv_q       <= RESERVED_RST;
			clr_q       <= '0;
			tag_q       <= '0;
			tag_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
			rem_q       <= '0;
			esz_q       <= '0;
			run_q       <= '0;
			want_q      <= '0;
			got_q       <= '0;
			k_q         <= '0;
			pos_q       <= '0;
			end_q       <= '0;
			ostart_q    <= '0;
			olen_q      <= '0;
			ostat_q     <= ST_GRANTED;
			olast_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BLOCK_COUNT: bc_q  <= cfg_data;
					REG_RESERVED:    rsv_q <= cfg_data;
					default: begin
					end
				endcase
			end

			tag_q     <= ram_addr;
			tag_vld_q <= !ram_we;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (operation == OP_RELEASE) begin
							pos_q   <= WW'(range_start);
							end_q   <= rel_end;
							state_q <= S_RRD;
						end else if (extent_size == 13'd0) begin
							ostart_q    <= '0;
							olen_q      <= '0;
							ostat_q     <= ST_INVALID;
							olast_q     <= 1'b1;
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							rem_q   <= required_blocks;
							esz_q   <= extent_size;
							want_q  <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					// Extent count by repeated subtraction, stopping once past the limit.
					if (rem_q >= esz_q && want_q <= EW'(MAX_EXTENTS)) begin
						rem_q  <= rem_q - esz_q;
						want_q <= want_q + EW'(1);
					end else if (want_q == '0 || want_q > EW'(MAX_EXTENTS)) begin
						ostart_q    <= '0;
						olen_q      <= '0;
						ostat_q     <= ST_INVALID;
						olast_q     <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						pos_q   <= WW'(rsv_q);
						run_q   <= '0;
						got_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (pos_q < hi_w && got_q < want_q) begin
						// Without a byte hit the map read is under way; try again next cycle.
						if (hit) begin
							pos_q <= pos_q + WW'(1);
							if (ram_rdata[pos_q[2:0]]) begin
								run_q <= '0;
							end else if (13'(run_q + 13'd1) == esz_q) begin
								run_q <= '0;
								got_q <= got_q + EW'(1);
							end else begin
								run_q <= run_q + 13'd1;
							end
						end
					end else if (got_q < want_q) begin
						ostart_q    <= '0;
						olen_q      <= '0;
						ostat_q     <= ST_NO_SPACE;
						olast_q     <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						k_q     <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_LSET;
				end
				S_LSET: begin
					pos_q   <= found_rd_q;
					run_q   <= '0;
					state_q <= S_MRD;
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					pos_q <= pos_q + WW'(1);
					run_q <= run_q + 13'd1;
					if (13'(run_q + 13'd1) == esz_q) begin
						ostart_q    <= found_rd_q[11:0];
						olen_q      <= esz_q;
						ostat_q     <= ST_GRANTED;
						olast_q     <= (EW'(k_q + EW'(1)) == want_q);
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						state_q <= S_MRD;
					end
				end
				S_RRD: begin
					if (pos_q < end_q) begin
						state_q <= S_RWR;
					end else begin
						ostart_q    <= '0;
						olen_q      <= '0;
						ostat_q     <= ST_RELEASED;
						olast_q     <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_RWR: begin
					pos_q   <= pos_q + WW'(1);
					state_q <= S_RRD;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (olast_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + EW'(1);
							state_q <= S_LOAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign extent_start  = ostart_q;
	assign extent_length = olen_q;
	assign status        = ostat_q;
	assign last          = olast_q;

endmodule

FILE: hw/rtl/bea_map_ram.sv
// Single-port byte memory holding the used map, one bit per block.
// Read data is registered; a write cycle does not read.
`timescale 1ns / 1ps

module bea_map_ram #(
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [7:0]               wdata,
	output logic [7:0]               rdata
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/bea_checker.sv
// Port-level checks of the bitmap extent allocator, attached by bind.
// Depends on bea_pkg; binds to bitmap_extent_allocator.
`timescale 1ns / 1ps

module bea_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [11:0]         extent_start,
	input logic [12:0]         extent_length,
	input bea_pkg::status_t    status,
	input logic                last
);
	import bea_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(extent_start)
			&& $stable(extent_length) && $stable(status) && $stable(last))
		else $error("result changed before its transfer");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("new item taken while a result is pending");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_GRANTED |-> last)
		else $error("non-grant result is not the final one");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_GRANTED |-> extent_start == 12'd0 && extent_length == 13'd0)
		else $error("non-grant result carries an extent");

	a_grant_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_GRANTED |-> extent_length != 13'd0)
		else $error("granted extent is empty");

endmodule

bind bitmap_extent_allocator bea_checker u_bea_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.extent_start  (extent_start),
	.extent_length (extent_length),
	.status        (status),
	.last          (last)
);
